>>> rtl/hrlc_pkg.sv
// Shared types, field widths and result codes for the HTTP request line checker.
package hrlc_pkg;

  // Field widths of the line and result transactions.
  localparam int BYTE_W    = 8;
  localparam int VERDICT_W = 3;
  localparam int KIND_W    = 2;
  localparam int PATH_W    = 13;

  // Default longest line; sets the saturation point of the path length.
  localparam int MAX_LINE_DEFAULT = 8192;

  // Verdict codes, in the order the checks take priority.
  localparam logic [VERDICT_W-1:0] VERDICT_OK          = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_FEW_SPACES  = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_EXTRA_SPACE = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD_METHOD  = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD_PATH    = 3'd4;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD_VERSION = 3'd5;

  // Method class codes.
  localparam logic [KIND_W-1:0] KIND_GET    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POST   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OTHER  = 2'd3;

  // One classified line byte as it travels from the front end to the back end.
  typedef struct packed {
    logic [BYTE_W-1:0] line_byte;
    logic              end_only;
    logic              last;
    logic              is_space;
    logic              is_query;
    logic              method_ok;
    logic              path_ok;
  } hrlc_item_t;

endpackage

>>> rtl/hrlc_if.sv
// Valid/ready channel interfaces for line bytes in and check results out.
interface hrlc_line_if import hrlc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] line_byte;
  logic              end_only;
  logic              last;

  modport source (output valid, line_byte, end_only, last, input ready);
  modport sink   (input valid, line_byte, end_only, last, output ready);
endinterface

interface hrlc_res_if import hrlc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [KIND_W-1:0]    method_kind;
  logic [PATH_W-1:0]    path_length;
  logic                 has_query;

  modport source (output valid, verdict, method_kind, path_length, has_query, input ready);
  modport sink   (input valid, verdict, method_kind, path_length, has_query, output ready);
endinterface

>>> rtl/hrlc_front.sv
// Front end: accepts line bytes, classifies each one and registers the result.
module hrlc_front import hrlc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  hrlc_line_if.sink   req,
  output logic        item_valid,
  input  logic        item_ready,
  output hrlc_item_t  item
);

  hrlc_item_t cls;
  logic       held_valid;

  function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
    is_alnum = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // Token characters allowed in a method name (8'h60 is the backtick).
  function automatic logic method_char_ok(input logic [BYTE_W-1:0] c);
    logic hit;
    case (c)
      "!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", 8'h60, "|", "~": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    method_char_ok = is_alnum(c) || hit;
  endfunction

  // Characters allowed in the path part of the target.
  function automatic logic path_char_ok(input logic [BYTE_W-1:0] c);
    logic hit;
    case (c)
      "/", ".", "-", "_", "?", "=", "&", "%", ":", "@", "!", "~", "*", "'", "(", ")", ",",
      "$": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    path_char_ok = is_alnum(c) || hit;
  endfunction

  // Classify the incoming byte.
  always_comb begin
    cls.line_byte = req.line_byte;
    cls.end_only  = req.end_only;
    cls.last      = req.last;
    cls.is_space  = (req.line_byte == " ");
    cls.is_query  = (req.line_byte == "?");
    cls.method_ok = method_char_ok(req.line_byte);
    cls.path_ok   = path_char_ok(req.line_byte);
  end

  // The stage takes a new transaction whenever it is empty or being drained.
  assign req.ready  = !held_valid || item_ready;
  assign item_valid = held_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req.ready) begin
      held_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item <= cls;
    end
  end

endmodule

>>> rtl/hrlc_queue.sv
// Two-entry queue that decouples the front end from the back end.
module hrlc_queue import hrlc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  hrlc_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output hrlc_item_t pop_item
);

  logic [1:0] count;
  hrlc_item_t slot0;
  hrlc_item_t slot1;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slot0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // The head always sits in slot0; a pop shifts slot1 forward.
  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= (push && count == 2'd1) ? push_item : slot1;
      if (push && count == 2'd2) begin
        slot1 <= push_item;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_item;
      end else begin
        slot1 <= push_item;
      end
    end
  end

endmodule

>>> rtl/hrlc_back.sv
// Back end: tracks the line structure byte by byte and registers the verdict.
module hrlc_back import hrlc_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  hrlc_item_t  item,
  hrlc_res_if.source  res
);

  localparam int PATH_MAX = (1 << PATH_W) - 1;
  localparam int PATH_CAP_INT = (MAX_LINE - 1 > PATH_MAX) ? PATH_MAX : MAX_LINE - 1;
  localparam logic [PATH_W-1:0] PATH_CAP = PATH_W'(PATH_CAP_INT);
  localparam logic [3:0] POS_MAX = 4'hF;

  typedef enum logic [1:0] {PH_METHOD, PH_TARGET, PH_VERSION} phase_t;

  phase_t            phase, phase_next;
  logic              method_good, method_good_next;
  logic              path_good, path_good_next;
  logic [3:0]        token_pos, token_pos_next;
  logic [2:0]        cands, cands_next;
  logic [1:0]        ver_ok, ver_ok_next;
  logic [PATH_W-1:0] path_count, path_count_next;
  logic              query_seen, query_seen_next;
  logic              extra_space, extra_space_next;

  logic                 out_valid;
  logic [VERDICT_W-1:0] out_verdict, verdict;
  logic [KIND_W-1:0]    out_kind, kind;
  logic [PATH_W-1:0]    out_plen, plen;
  logic                 out_query, has_q;
  logic                 pop;

  function automatic logic [BYTE_W-1:0] get_at(input logic [3:0] pos);
    case (pos)
      4'd0: get_at = "G";
      4'd1: get_at = "E";
      4'd2: get_at = "T";
      default: get_at = 8'h00;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] post_at(input logic [3:0] pos);
    case (pos)
      4'd0: post_at = "P";
      4'd1: post_at = "O";
      4'd2: post_at = "S";
      4'd3: post_at = "T";
      default: post_at = 8'h00;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] delete_at(input logic [3:0] pos);
    case (pos)
      4'd0: delete_at = "D";
      4'd1: delete_at = "E";
      4'd2: delete_at = "L";
      4'd3: delete_at = "E";
      4'd4: delete_at = "T";
      4'd5: delete_at = "E";
      default: delete_at = 8'h00;
    endcase
  endfunction

  // Common prefix of both accepted versions.
  function automatic logic [BYTE_W-1:0] version_at(input logic [3:0] pos);
    case (pos)
      4'd0: version_at = "H";
      4'd1: version_at = "T";
      4'd2: version_at = "T";
      4'd3: version_at = "P";
      4'd4: version_at = "/";
      4'd5: version_at = "1";
      4'd6: version_at = ".";
      default: version_at = 8'h00;
    endcase
  endfunction

  // A line end only waits when the result register is still full.
  assign item_ready = !item.last || !out_valid || res.ready;
  assign pop        = item_valid && item_ready;

  // Next parse state after the current transaction.
  always_comb begin
    phase_next       = phase;
    method_good_next = method_good;
    path_good_next   = path_good;
    token_pos_next   = token_pos;
    cands_next       = cands;
    ver_ok_next      = ver_ok;
    path_count_next  = path_count;
    query_seen_next  = query_seen;
    extra_space_next = extra_space;
    if (!item.end_only) begin
      if (item.is_space) begin
        unique case (phase)
          PH_METHOD: begin
            cands_next     = cands & {token_pos == 4'd6, token_pos == 4'd4, token_pos == 4'd3};
            phase_next     = PH_TARGET;
            token_pos_next = 4'd0;
          end
          PH_TARGET: begin
            phase_next     = PH_VERSION;
            token_pos_next = 4'd0;
          end
          default: begin
            extra_space_next = 1'b1;
          end
        endcase
      end else begin
        unique case (phase)
          PH_METHOD: begin
            method_good_next = method_good && item.method_ok;
            cands_next[0] = cands[0] && token_pos < 4'd3 && item.line_byte == get_at(token_pos);
            cands_next[1] = cands[1] && token_pos < 4'd4 && item.line_byte == post_at(token_pos);
            cands_next[2] = cands[2] && token_pos < 4'd6
                            && item.line_byte == delete_at(token_pos);
            if (token_pos != POS_MAX) begin
              token_pos_next = token_pos + 4'd1;
            end
          end
          PH_TARGET: begin
            // Bytes after the first question mark are not checked or counted.
            if (!query_seen) begin
              if (item.is_query) begin
                query_seen_next = 1'b1;
              end else begin
                path_good_next = path_good && item.path_ok;
                if (path_count < PATH_CAP) begin
                  path_count_next = path_count + PATH_W'(1);
                end
              end
            end
          end
          default: begin
            if (token_pos < 4'd7) begin
              if (item.line_byte != version_at(token_pos)) begin
                ver_ok_next = 2'b00;
              end
            end else if (token_pos == 4'd7) begin
              ver_ok_next = ver_ok & {item.line_byte == "0", item.line_byte == "1"};
            end else begin
              ver_ok_next = 2'b00;
            end
            if (token_pos != POS_MAX) begin
              token_pos_next = token_pos + 4'd1;
            end
          end
        endcase
      end
    end
  end

  // Verdict for a line that ends with this transaction.
  always_comb begin
    plen  = '0;
    has_q = 1'b0;
    if (phase_next != PH_VERSION) begin
      verdict = VERDICT_FEW_SPACES;
    end else if (extra_space_next) begin
      verdict = VERDICT_EXTRA_SPACE;
    end else begin
      plen  = path_count_next;
      has_q = query_seen_next;
      if (!method_good_next) begin
        verdict = VERDICT_BAD_METHOD;
      end else if (!path_good_next) begin
        verdict = VERDICT_BAD_PATH;
      end else if (ver_ok_next == 2'b00 || token_pos_next != 4'd8) begin
        verdict = VERDICT_BAD_VERSION;
      end else begin
        verdict = VERDICT_OK;
      end
    end
    kind = KIND_OTHER;
    if (verdict == VERDICT_OK) begin
      // An empty or unknown method leaves no candidate and stays in the other class.
      priority if (cands_next[0]) begin
        kind = KIND_GET;
      end else if (cands_next[1]) begin
        kind = KIND_POST;
      end else if (cands_next[2]) begin
        kind = KIND_DELETE;
      end else begin
        kind = KIND_OTHER;
      end
    end
  end

  // Parse state and result register; a line end restores the start state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_METHOD;
      method_good <= 1'b1;
      path_good   <= 1'b1;
      token_pos   <= 4'd0;
      cands       <= 3'b111;
      ver_ok      <= 2'b11;
      path_count  <= '0;
      query_seen  <= 1'b0;
      extra_space <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && res.ready && !(pop && item.last)) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (item.last) begin
          phase       <= PH_METHOD;
          method_good <= 1'b1;
          path_good   <= 1'b1;
          token_pos   <= 4'd0;
          cands       <= 3'b111;
          ver_ok      <= 2'b11;
          path_count  <= '0;
          query_seen  <= 1'b0;
          extra_space <= 1'b0;
          out_valid   <= 1'b1;
          out_verdict <= verdict;
          out_kind    <= kind;
          out_plen    <= plen;
          out_query   <= has_q;
        end else begin
          phase       <= phase_next;
          method_good <= method_good_next;
          path_good   <= path_good_next;
          token_pos   <= token_pos_next;
          cands       <= cands_next;
          ver_ok      <= ver_ok_next;
          path_count  <= path_count_next;
          query_seen  <= query_seen_next;
          extra_space <= extra_space_next;
        end
      end
    end
  end

  assign res.valid       = out_valid;
  assign res.verdict     = out_verdict;
  assign res.method_kind = out_kind;
  assign res.path_length = out_plen;
  assign res.has_query   = out_query;

endmodule

>>> rtl/http_request_line_checker.sv
// A line's last byte passes the front end register, a queue slot and the result register before its result is valid.
// Throughput: one byte per cycle while nothing stalls; the back end updates its parse state for each byte it takes.
// A line end stalls only while the previous result still waits in the output register.
// Reset: synchronous, active high; clears the queue, the parse state and the result valid.
// No clearing pass is needed, so bytes are taken in the first cycle after reset.
module http_request_line_checker import hrlc_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  hrlc_line_if.sink   req,
  hrlc_res_if.source  res
);

  logic       fr_valid;
  logic       fr_ready;
  hrlc_item_t fr_item;
  logic       q_valid;
  logic       q_ready;
  hrlc_item_t q_item;

  // Byte classification stage.
  hrlc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .item_valid (fr_valid),
    .item_ready (fr_ready),
    .item       (fr_item)
  );

  // Decoupling queue.
  hrlc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Parse state and result.
  hrlc_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res        (res)
  );

  // A new result only follows a line end taken from the queue.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(q_valid && q_ready && q_item.last))
    else $error("result appeared without a line end");

  // A classified byte held back by a full queue stays in place.
  assert property (@(posedge clk) disable iff (rst)
    (fr_valid && !fr_ready) |=> (fr_valid && $stable(fr_item)))
    else $error("front end lost a stalled transaction");

  // Rejected lines never report a method class.
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.verdict != VERDICT_OK) |-> (res.method_kind == KIND_OTHER))
    else $error("method class on a rejected line");

  // Space errors carry no path information.
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.verdict == VERDICT_FEW_SPACES || res.verdict == VERDICT_EXTRA_SPACE))
    |-> (res.path_length == '0 && !res.has_query))
    else $error("path fields set on a space error");

endmodule

>>> dv/hrlc_result_checker.sv
// Watches both channels of the request line checker, predicts each line's result and compares.
module hrlc_result_checker import hrlc_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  hrlc_line_if  line,
  hrlc_res_if   res,
  output int    mismatches,
  output int    results_owed
);

  // Path length stops counting here.
  localparam int PATH_LIMIT = (MAX_LINE - 1 > 8191) ? 8191 : MAX_LINE - 1;

  // Which token of the request line the parser is in.
  typedef enum logic [1:0] {SEC_METHOD, SEC_TARGET, SEC_VERSION} section_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [KIND_W-1:0]    kind;
    logic [PATH_W-1:0]    plen;
    logic                 query;
  } line_result_t;

  // Parse state of the line being received.
  section_t          section;
  logic              method_good;
  logic              path_good;
  logic [3:0]        tok_pos;
  logic [2:0]        method_live;  // bit 0 GET, bit 1 POST, bit 2 DELETE
  logic [1:0]        ver_live;     // bit 0 HTTP/1.1, bit 1 HTTP/1.0
  logic [PATH_W-1:0] path_len;
  logic              query_flag;
  logic              extra_space;

  line_result_t owed_results[$];
  int           fails = 0;

  assign mismatches = fails;

  task automatic report(input string what, input int got, input int want);
    if (fails < 40) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
    fails++;
  endtask

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // Token characters allowed in a method name (8'h60 is the backtick).
  function automatic logic method_char_ok(input logic [7:0] c);
    case (c)
      "!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", 8'h60, "|", "~": return 1'b1;
      default: return is_alnum(c);
    endcase
  endfunction

  // Characters allowed in the path part of the target.
  function automatic logic path_char_ok(input logic [7:0] c);
    case (c)
      "/", ".", "-", "_", "?", "=", "&", "%", ":", "@", "!", "~", "*", "'", "(", ")", ",",
      "$": return 1'b1;
      default: return is_alnum(c);
    endcase
  endfunction

  function automatic logic word_at(input string w, input int pos, input logic [7:0] c);
    return pos < w.len() && w[pos] == c;
  endfunction

  function void clear_parse();
    section     = SEC_METHOD;
    method_good = 1'b1;
    path_good   = 1'b1;
    tok_pos     = '0;
    method_live = 3'b111;
    ver_live    = 2'b11;
    path_len    = '0;
    query_flag  = 1'b0;
    extra_space = 1'b0;
  endfunction

  // Advances the parse state by one line byte.
  function void absorb_byte(input logic [7:0] c);
    string ver_prefix;
    ver_prefix = "HTTP/1.";
    if (c == " ") begin
      case (section)
        SEC_METHOD: begin
          // A method word only survives if its length matches exactly.
          if (tok_pos != 4'd3) method_live[0] = 1'b0;
          if (tok_pos != 4'd4) method_live[1] = 1'b0;
          if (tok_pos != 4'd6) method_live[2] = 1'b0;
          section = SEC_TARGET;
          tok_pos = '0;
        end
        SEC_TARGET: begin
          section = SEC_VERSION;
          tok_pos = '0;
        end
        default: extra_space = 1'b1;
      endcase
    end else begin
      case (section)
        SEC_METHOD: begin
          if (!method_char_ok(c)) method_good = 1'b0;
          if (!word_at("GET", tok_pos, c)) method_live[0] = 1'b0;
          if (!word_at("POST", tok_pos, c)) method_live[1] = 1'b0;
          if (!word_at("DELETE", tok_pos, c)) method_live[2] = 1'b0;
          if (tok_pos != 4'd15) tok_pos = tok_pos + 4'd1;
        end
        SEC_TARGET: begin
          // Everything after the first question mark is query and goes unchecked.
          if (!query_flag) begin
            if (c == "?") begin
              query_flag = 1'b1;
            end else begin
              if (!path_char_ok(c)) path_good = 1'b0;
              if (path_len < PATH_LIMIT) path_len = path_len + 1'b1;
            end
          end
        end
        default: begin
          if (tok_pos < 4'd7) begin
            if (c != ver_prefix[tok_pos]) ver_live = 2'b00;
          end else if (tok_pos == 4'd7) begin
            if (c != "1") ver_live[0] = 1'b0;
            if (c != "0") ver_live[1] = 1'b0;
          end else begin
            ver_live = 2'b00;
          end
          if (tok_pos != 4'd15) tok_pos = tok_pos + 4'd1;
        end
      endcase
    end
  endfunction

  // Result of the line as it stands, checks taken in priority order.
  function automatic line_result_t close_line();
    line_result_t r;
    r.kind  = KIND_OTHER;
    r.plen  = '0;
    r.query = 1'b0;
    if (section != SEC_VERSION) begin
      r.verdict = VERDICT_FEW_SPACES;
    end else if (extra_space) begin
      r.verdict = VERDICT_EXTRA_SPACE;
    end else begin
      r.plen  = path_len;
      r.query = query_flag;
      if (!method_good) r.verdict = VERDICT_BAD_METHOD;
      else if (!path_good) r.verdict = VERDICT_BAD_PATH;
      else if (ver_live == 2'b00 || tok_pos != 4'd8) r.verdict = VERDICT_BAD_VERSION;
      else r.verdict = VERDICT_OK;
    end
    if (r.verdict == VERDICT_OK) begin
      if (method_live[0]) r.kind = KIND_GET;
      else if (method_live[1]) r.kind = KIND_POST;
      else if (method_live[2]) r.kind = KIND_DELETE;
    end
    return r;
  endfunction

  // Compare each result transaction first, then take the line transaction of the same edge.
  always @(posedge clk) begin
    line_result_t want;
    if (rst) begin
      clear_parse();
      owed_results.delete();
      results_owed <= 0;
    end else begin
      if (res.valid && res.ready) begin
        if (owed_results.size() == 0) begin
          report("result with none owed, verdict", res.verdict, -1);
        end else begin
          want = owed_results.pop_front();
          if (res.verdict != want.verdict) report("verdict", res.verdict, want.verdict);
          if (res.method_kind != want.kind) report("method_kind", res.method_kind, want.kind);
          if (res.path_length != want.plen) report("path_length", res.path_length, want.plen);
          if (res.has_query != want.query) report("has_query", res.has_query, want.query);
        end
      end
      if (line.valid && line.ready) begin
        if (!line.end_only) absorb_byte(line.line_byte);
        if (line.last) begin
          owed_results.push_back(close_line());
          clear_parse();
        end
      end
      results_owed <= owed_results.size();
    end
  end

endmodule

>>> dv/http_request_line_checker_tb.sv
// Top of the request line checker testbench: clock, reset, line stimulus and result stalls.
module http_request_line_checker_tb;
  import hrlc_pkg::*;

  logic clk;
  logic rst;

  hrlc_line_if line_ch ();
  hrlc_res_if  res_ch ();

  int fail_count;
  int owed_count;
  int hold_asked = 0;

  logic [7:0] line_buf[$];
  int burst_left = 0;
  int items_sent = 0;
  int lines_sent = 0;

  http_request_line_checker DUT (
    .clk (clk),
    .rst (rst),
    .req (line_ch),
    .res (res_ch)
  );

  hrlc_result_checker result_check (
    .clk          (clk),
    .rst          (rst),
    .line         (line_ch),
    .res          (res_ch),
    .mismatches   (fail_count),
    .results_owed (owed_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Offers one transaction, opening a new burst after a random gap when the last one ran out.
  task automatic send_item(input logic [7:0] b, input logic eo, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        line_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    line_ch.valid     <= 1'b1;
    line_ch.line_byte <= b;
    line_ch.end_only  <= eo;
    line_ch.last      <= lst;
    do @(posedge clk); while (!line_ch.ready);
    items_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // Sends the buffered line, now and then with a stray end-only transaction in between.
  task automatic send_line(input bit end_marker);
    bit marker;
    marker = end_marker || line_buf.size() == 0;
    foreach (line_buf[i]) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      send_item(line_buf[i], 1'b0, !marker && i == line_buf.size() - 1);
    end
    if (marker) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    line_buf.delete();
    lines_sent++;
  endtask

  // Mostly well-formed lines with random content; the rest is noise or damaged lines.
  task automatic build_random_line();
    string tok_set;
    string path_set;
    int form;
    int n;
    int idx;
    tok_set  = "abcxyzGETPOSDL019!#$%&'*+-.^_|~";
    path_set = "abcxyzABZ0189/.-_=&%:@!~*'(),$";
    form = $urandom_range(0, 9);
    if (form < 2) begin
      n = $urandom_range(0, 24);
      repeat (n) begin
        line_buf.push_back(($urandom_range(0, 3) == 0) ? 8'h20 : 8'($urandom_range(0, 255)));
      end
    end else begin
      case ($urandom_range(0, 5))
        0: add_text("GET");
        1: add_text("POST");
        2: add_text("DELETE");
        3: begin
          n = $urandom_range(0, 18);
          repeat (n) line_buf.push_back(tok_set[$urandom_range(0, tok_set.len() - 1)]);
        end
        4: begin
          case ($urandom_range(0, 3))
            0: add_text("GETS");
            1: add_text("POS");
            2: add_text("DELETE_");
            default: add_text("get");
          endcase
        end
        default: ;
      endcase
      add_text(" ");
      if ($urandom_range(0, 5) != 0) add_text("/");
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      repeat (n) line_buf.push_back(path_set[$urandom_range(0, path_set.len() - 1)]);
      if ($urandom_range(0, 2) == 0) begin
        add_text("?");
        n = $urandom_range(0, 8);
        repeat (n) line_buf.push_back(8'($urandom_range(33, 255)));
      end
      add_text(" ");
      case ($urandom_range(0, 9))
        0, 1, 2, 3: add_text("HTTP/1.1");
        4, 5, 6: add_text("HTTP/1.0");
        7: add_text("HTTP/1.");
        8: add_text("HTTP/2.0");
        default: begin
          add_text("HTTP/1.1");
          line_buf.push_back(8'($urandom_range(0, 255)));
        end
      endcase
      if (form == 9) begin
        idx = $urandom_range(0, line_buf.size() - 1);
        if ($urandom_range(0, 1) == 0) line_buf[idx] = 8'($urandom_range(0, 255));
        else line_buf.insert(idx, 8'h20);
      end
    end
  endtask

  // Stops offering and waits until every owed result has been taken.
  task automatic wait_for_results();
    line_ch.valid <= 1'b0;
    @(posedge clk);
    wait (owed_count == 0);
    @(posedge clk);
  endtask

  // Result side: randomly chosen stall patterns, plus requested hold-offs.
  initial begin
    int holds_seen;
    int mode;
    int tick;
    holds_seen = 0;
    mode = 0;
    tick = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != holds_seen) begin
        holds_seen = hold_asked;
        res_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        tick++;
        if (tick % 48 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom_range(0, 1));
          2: res_ch.ready <= (tick % 3 == 0);
          default: res_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Line side: directed lines, then random lines with one long result hold-off.
  initial begin
    int random_start;
    int lines_at_start;
    rst               <= 1'b1;
    line_ch.valid     <= 1'b0;
    line_ch.line_byte <= '0;
    line_ch.end_only  <= 1'b0;
    line_ch.last      <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Empty line: an end-only transaction marked last.
    send_line(1'b0);
    // An end-only transaction carrying a space byte must be ignored.
    send_item(8'h20, 1'b1, 1'b0);
    add_text("GET / HTTP/1.1");
    send_line(1'b0);
    add_text("POST /a/b.c HTTP/1.0");
    send_line(1'b0);
    add_text("DELETE /x?k=v&z HTTP/1.1");
    send_line(1'b1);
    // Empty method is accepted but matches no known word.
    add_text(" /p HTTP/1.0");
    send_line(1'b0);
    add_text("PATCH /q HTTP/1.1");
    send_line(1'b0);
    add_text("GET /abc");
    send_line(1'b0);
    add_text("GET / HTTP/1.1 ");
    send_line(1'b0);
    add_text("GET /a b HTTP/1.1");
    send_line(1'b1);
    // High bytes are never method or path characters.
    add_text("G");
    line_buf.push_back(8'h80);
    add_text("T / HTTP/1.1");
    send_line(1'b0);
    add_text("GET /a<b HTTP/1.1");
    send_line(1'b0);
    add_text("GET /a");
    line_buf.push_back(8'hff);
    add_text(" HTTP/1.1");
    send_line(1'b0);
    // Query bytes are not checked, a second question mark included.
    add_text("GET /ok?<>?");
    line_buf.push_back(8'h01);
    line_buf.push_back(8'hfe);
    add_text(" HTTP/1.1");
    send_line(1'b0);
    add_text("GET / HTTP/2.0");
    send_line(1'b0);
    add_text("GET / HTTP/1.10");
    send_line(1'b0);
    add_text("GET / HTTP/1.");
    send_line(1'b1);
    add_text("GET / ");
    send_line(1'b0);
    // Over-long method and version tokens saturate their position count.
    add_text("GETGETGETGETGETGETGET / HTTP/1.1");
    send_line(1'b0);
    add_text("GET / HTTP/1.1HTTP/1.1HTTP/1.1");
    send_line(1'b0);
    // Method failure outranks path and version failures.
    add_text("G@T /a<b HTTP/9");
    send_line(1'b0);
    add_text("GET /%7E~!*'(),$:@=& HTTP/1.0");
    send_line(1'b0);
    add_text("A!#$%&'*+-.^_");
    line_buf.push_back(8'h60);
    add_text("|~z9 / HTTP/1.1");
    send_line(1'b0);
    wait_for_results();

    random_start   = items_sent;
    lines_at_start = lines_sent;
    while (items_sent < 500 || lines_sent < lines_at_start + 6) begin
      if (lines_sent == lines_at_start + 1) begin
        // Hold off results while lines keep coming back to back.
        hold_asked <= hold_asked + 1;
        burst_left = 100000;
        repeat (3) begin
          build_random_line();
          send_line($urandom_range(0, 4) == 0);
        end
        burst_left = 0;
        wait_for_results();
      end
      build_random_line();
      send_line($urandom_range(0, 4) == 0);
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("http_request_line_checker_tb: done, clean");
    end else begin
      $display("http_request_line_checker_tb: done, errors");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #3_200_000;
    $display("http_request_line_checker_tb: done, errors");
    $finish;
  end

endmodule
